// File: design/hftq_pkg.sv
package hftq_pkg;

  // Register indexes, taken from paddr[3:2] (registers lie at byte addresses 4*i).
  localparam logic [1:0] REG_GRID_COLS    = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  GRID_COLS_RST    = 8'd255;
  localparam logic [7:0]  GRID_ROWS_RST    = 8'd255;
  localparam logic [15:0] HEIGHT_SCALE_RST = 16'd1638;

  // Field widths.
  localparam int HGT_W = 18;
  localparam int SMP_W = 10;
  localparam int CRD_W = 18;  // signed grid coordinates
  localparam int ADR_W = 17;  // linear sample address inside the grid in use

  localparam logic [HGT_W-1:0] HEIGHT_MAX = 18'h3FFFF;

endpackage

// File: design/heightfield_triangle_height_query.sv
// Heightfield triangle height query.
//
// Input channel (in_valid/in_ready) carries one word per item. A word with mode 0
// writes load_value into the sample store at load_index and produces no result.
// A word with mode 1 is a height query at (query_x, query_y) and produces exactly
// one result word on the output channel (out_valid/out_ready): the interpolated
// height and an out_of_range flag. Results leave in the order of the queries.
// One word is accepted every cycle unless the pipeline is full and stalled: the
// store is split into two banks by address parity, each with two read ports, so
// the four corner samples of a cell are read from the store in the same cycle.
// When the receiver stalls, each stage holds its word and empty stages still fill,
// so in_ready only falls once every stage holds a word. Synchronous reset empties
// the pipeline and restores the registers; sample contents are not cleared and a
// sample must be loaded before a query reads it. The APB port writes grid_cols,
// grid_rows and height_scale at byte addresses 0, 4 and 8; write it only while
// no word is in flight.
module heightfield_triangle_height_query
  import hftq_pkg::*;
#(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [15:0]            load_index,
  input  logic [SMP_W-1:0]       load_value,
  input  logic signed [15:0]     query_x,
  input  logic signed [15:0]     query_y,
  // output channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HGT_W-1:0]       height,
  output logic                   out_of_range
);

  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int BANK_D  = (DEPTH + 1) / 2;
  localparam int BANK_AW = $clog2(BANK_D);
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);
  localparam int PW   = FRAC_BITS + 13;  // corner term product
  localparam int SUMW = FRAC_BITS + 14;  // signed sum of the three terms
  localparam int SW   = FRAC_BITS + 10;  // unsigned interpolated sum

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  grid_cols;
  logic [7:0]  grid_rows;
  logic [15:0] height_scale;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols    <= GRID_COLS_RST;
      grid_rows    <= GRID_ROWS_RST;
      height_scale <= HEIGHT_SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GRID_COLS:    grid_cols    <= pwdata[7:0];
        REG_GRID_ROWS:    grid_rows    <= pwdata[7:0];
        REG_HEIGHT_SCALE: height_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRID_COLS:    prdata = {24'd0, grid_cols};
      REG_GRID_ROWS:    prdata = {24'd0, grid_rows};
      REG_HEIGHT_SCALE: prdata = {16'd0, height_scale};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage valids and hold logic. A stage takes a new word when it is empty or
  // its word moves on. Loads leave the pipeline after writing the store.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;

  assign r6 = !v6 || out_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  // Stage 1: cell coordinates from the query position.
  logic signed [CRD_W-1:0] qx_e, qy_e, nx, ny, a_s, b_s, rt_c, cl_c;
  logic [7:0]              a8, b8;

  assign qx_e = CRD_W'(query_x);
  assign qy_e = CRD_W'(query_y);
  assign nx   = qx_e >>> FRAC_BITS;
  assign ny   = qy_e >>> FRAC_BITS;
  assign a8   = 8'(grid_rows - 8'd1) >> 1;
  assign b8   = 8'(grid_cols - 8'd1) >> 1;
  assign a_s  = $signed({{(CRD_W-8){1'b0}}, a8});
  assign b_s  = $signed({{(CRD_W-8){1'b0}}, b8});
  // The cell's upper row is that of ny+1; its left column is that of nx.
  assign rt_c = a_s - ny - CRD_W'(1);
  assign cl_c = b_s + nx;

  logic                    mode1;
  logic [15:0]             lidx1;
  logic [SMP_W-1:0]        lval1;
  logic [FRAC_BITS-1:0]    fx1, fy1;
  logic signed [CRD_W-1:0] rt1, cl1;

  // Stage 2: range check and row base address.
  logic signed [CRD_W-1:0] rows_s, cols_s;
  logic                    oor_c1;
  logic [15:0]             base_c;

  assign rows_s = $signed({{(CRD_W-8){1'b0}}, grid_rows});
  assign cols_s = $signed({{(CRD_W-8){1'b0}}, grid_cols});
  assign oor_c1 = (grid_rows < 8'd2) || (grid_cols < 8'd2) ||
                  (rt1 < 0) || (rt1 >= rows_s - CRD_W'(1)) ||
                  (cl1 < 0) || (cl1 >= cols_s - CRD_W'(1));
  assign base_c = {8'd0, rt1[7:0]} * {8'd0, grid_cols};

  logic                 mode2, oor2;
  logic [15:0]          lidx2, base2;
  logic [SMP_W-1:0]     lval2;
  logic [FRAC_BITS-1:0] fx2, fy2;
  logic [7:0]           cl2;

  // Stage 3: corner addresses, bank split and the store itself. Sample pairs at
  // neighbouring addresses always fall in different banks.
  logic [ADR_W-1:0] a_top, a_bot;
  logic [31:0]      a_top_w, a_bot_w, ev_top, od_top, ev_bot, od_bot;
  logic [31:0]      wr_w, wr_loc;
  logic             oor_c2, wr_en;

  assign a_top   = {1'b0, base2} + {{(ADR_W-8){1'b0}}, cl2};
  assign a_bot   = a_top + {{(ADR_W-8){1'b0}}, grid_cols};
  assign a_top_w = {{(32-ADR_W){1'b0}}, a_top};
  assign a_bot_w = {{(32-ADR_W){1'b0}}, a_bot};
  assign ev_top  = (a_top_w + 32'd1) >> 1;
  assign od_top  = a_top_w >> 1;
  assign ev_bot  = (a_bot_w + 32'd1) >> 1;
  assign od_bot  = a_bot_w >> 1;
  assign oor_c2  = oor2 || ((a_bot_w + 32'd1) >= DEPTH_W);

  assign wr_w   = {16'd0, lidx2};
  assign wr_loc = wr_w >> 1;
  assign wr_en  = r3 && v2 && !mode2 && (wr_w < DEPTH_W);

  logic [SMP_W-1:0] bank0 [BANK_D];
  logic [SMP_W-1:0] bank1 [BANK_D];
  logic [SMP_W-1:0] b0_top, b0_bot, b1_top, b1_bot;

  always_ff @(posedge clk) begin
    if (wr_en && !lidx2[0]) begin
      bank0[wr_loc[BANK_AW-1:0]] <= lval2;
    end
    if (r3) begin
      b0_top <= bank0[ev_top[BANK_AW-1:0]];
      b0_bot <= bank0[ev_bot[BANK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && lidx2[0]) begin
      bank1[wr_loc[BANK_AW-1:0]] <= lval2;
    end
    if (r3) begin
      b1_top <= bank1[od_top[BANK_AW-1:0]];
      b1_bot <= bank1[od_bot[BANK_AW-1:0]];
    end
  end

  logic                 oor3, top_odd3, bot_odd3;
  logic [FRAC_BITS-1:0] fx3, fy3;

  // Stage 4: pick the triangle and form its two slope products.
  logic [SMP_W-1:0]       h00, h01, h10, h11, base_h;
  logic [FRAC_BITS:0]     one_v, m1, m2;
  logic signed [SMP_W:0]  d1, d2;
  logic signed [FRAC_BITS+1:0] m1_s, m2_s;
  logic signed [PW-1:0]   p1_c, p2_c;

  assign h01   = top_odd3 ? b1_top : b0_top;
  assign h11   = top_odd3 ? b0_top : b1_top;
  assign h00   = bot_odd3 ? b1_bot : b0_bot;
  assign h10   = bot_odd3 ? b0_bot : b1_bot;
  assign one_v = {1'b1, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (fx3 < fy3) begin
      // Upper-left triangle, based on the corner above the cell origin.
      base_h = h01;
      m1     = {1'b0, fx3};
      d1     = $signed({1'b0, h11}) - $signed({1'b0, h01});
      m2     = one_v - {1'b0, fy3};
      d2     = $signed({1'b0, h00}) - $signed({1'b0, h01});
    end else begin
      // Lower-right triangle, based on the corner right of the cell origin.
      base_h = h10;
      m1     = one_v - {1'b0, fx3};
      d1     = $signed({1'b0, h00}) - $signed({1'b0, h10});
      m2     = {1'b0, fy3};
      d2     = $signed({1'b0, h11}) - $signed({1'b0, h10});
    end
  end

  assign m1_s = $signed({1'b0, m1});
  assign m2_s = $signed({1'b0, m2});
  assign p1_c = m1_s * d1;
  assign p2_c = m2_s * d2;

  logic                 oor4;
  logic [SMP_W-1:0]     base4;
  logic signed [PW-1:0] p1_4, p2_4;

  // Stage 5: plane sum. The weights are non-negative and add up to one, so the
  // sum stays within the sample range scaled by one.
  logic signed [SUMW-1:0] sum_c;
  logic [SW-1:0]          s_c;

  assign sum_c = $signed({{(SUMW-SMP_W-FRAC_BITS){1'b0}}, base4, {FRAC_BITS{1'b0}}})
                 + p1_4 + p2_4;
  assign s_c   = sum_c[SUMW-1] ? '0 : sum_c[SW-1:0];

  logic          oor5;
  logic [SW-1:0] s5;

  // Stage 6: scale, truncate and saturate.
  logic [SW+15:0]    prod;
  logic [31:0]       hv32;
  logic [HGT_W-1:0]  height_next;

  assign prod = {16'd0, s5} * {{SW{1'b0}}, height_scale};
  assign hv32 = 32'(prod >> 16);
  assign height_next = oor5 ? '0 :
                       (hv32 > {{(32-HGT_W){1'b0}}, HEIGHT_MAX}) ? HEIGHT_MAX :
                       hv32[HGT_W-1:0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2 && mode2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (r1) begin
      mode1 <= mode;
      lidx1 <= load_index;
      lval1 <= load_value;
      fx1   <= query_x[FRAC_BITS-1:0];
      fy1   <= query_y[FRAC_BITS-1:0];
      rt1   <= rt_c;
      cl1   <= cl_c;
    end
    if (r2) begin
      mode2 <= mode1;
      lidx2 <= lidx1;
      lval2 <= lval1;
      fx2   <= fx1;
      fy2   <= fy1;
      oor2  <= oor_c1;
      base2 <= base_c;
      cl2   <= cl1[7:0];
    end
    if (r3) begin
      oor3     <= oor_c2;
      fx3      <= fx2;
      fy3      <= fy2;
      top_odd3 <= a_top[0];
      bot_odd3 <= a_bot[0];
    end
    if (r4) begin
      oor4  <= oor3;
      base4 <= base_h;
      p1_4  <= p1_c;
      p2_4  <= p2_c;
    end
    if (r5) begin
      oor5 <= oor4;
      s5   <= s_c;
    end
    if (r6) begin
      height       <= height_next;
      out_of_range <= oor5;
    end
  end

  assign out_valid = v6;

endmodule

// File: tb/heightfield_triangle_height_query_tb.sv
`timescale 1ns / 1ps

module heightfield_triangle_height_query_tb
  import hftq_pkg::*;
();

  // Geometry of the block as instantiated (default parameters).
  localparam int FRAC_BITS   = 8;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int STORE_DEPTH = 256 * 256;

  // Operation carried by the mode field of an input word.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Cycles allowed for loads still in flight once the last result has left;
  // enough for any load to pass through the pipeline and write the store.
  localparam int SETTLE_CYCLES = 12;
  // Length of the single long hold-off on the output side.
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    logic                 mode;
    logic [15:0]          idx;
    logic [SMP_W-1:0]     val;
    logic signed [15:0]   qx;
    logic signed [15:0]   qy;
    bit                   fixed;   // expected result typed into the table
    logic [HGT_W-1:0]     fh;
    logic                 foor;
  } in_word_t;

  typedef struct {
    logic [HGT_W-1:0] height;
    logic             out_of_range;
  } height_word_t;

  typedef struct {
    int cols;
    int rows;
    int scale;    // a negative value asks for a random scale
    int words;
  } setting_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel, penable, pwrite;
  logic [3:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid, in_ready;
  logic                 mode;
  logic [15:0]          load_index;
  logic [SMP_W-1:0]     load_value;
  logic signed [15:0]   query_x, query_y;
  logic                 out_valid, out_ready;
  logic [HGT_W-1:0]     height;
  logic                 out_of_range;

  heightfield_triangle_height_query DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .load_index  (load_index),
    .load_value  (load_value),
    .query_x     (query_x),
    .query_y     (query_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .height      (height),
    .out_of_range(out_of_range)
  );

  always #5 clk = ~clk;

  // Our own copy of the block's state: the configuration registers and the
  // sample store, updated as words are accepted and registers are written.
  logic [7:0]        cfg_cols  = GRID_COLS_RST;
  logic [7:0]        cfg_rows  = GRID_ROWS_RST;
  logic [15:0]       cfg_scale = HEIGHT_SCALE_RST;
  logic [SMP_W-1:0]  samples [STORE_DEPTH];

  // Which store entries the stimulus has loaded so far. A query is only ever
  // sent once all four corners of its cell are marked here, because reading
  // an entry that was never written has no defined result.
  bit                loaded [STORE_DEPTH];

  height_word_t      heights_due [$];
  int                errors = 0;
  int                words_sent = 0;

  // Set while the current word carries a hand-typed expectation.
  bit                cur_fixed = 1'b0;
  height_word_t      cur_expected;

  // Flags shared between the sender, the receiver and the main sequence.
  bit                hold_req = 1'b0;
  bit                tx_quiet = 1'b0;
  bit                rx_quiet = 1'b0;

  // Directed words, run straight after reset with the default 255 x 255 grid,
  // whose centre is row 127, column 127. The cell at grid point (0,0) spans
  // rows 126..127 and columns 127..128, that is entries 32257, 32258 (upper
  // row) and 32512, 32513 (lower row). The cell is first loaded flat at zero,
  // then reloaded with a slope that includes the largest 10-bit value.
  in_word_t directed_words [22] = '{
    '{MODE_LOAD,  16'd32257, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd32258, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd32512, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd32513, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    // Flat cell: zero height, inside the grid.
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0000, 16'sh0000, 1'b1, 18'd0, 1'b0},
    // Coordinate extremes all fall off one edge of the grid or another.
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh7FFF, 16'sh0000, 1'b1, 18'd0, 1'b1},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh8000, 16'sh0000, 1'b1, 18'd0, 1'b1},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0000, 16'sh7FFF, 1'b1, 18'd0, 1'b1},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0000, 16'sh8000, 1'b1, 18'd0, 1'b1},
    // Sloped cell; the first value lies above the largest RGB sum.
    '{MODE_LOAD,  16'd32257, 10'd1023, 16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd32258, 10'd765,  16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd32512, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd32513, 10'd512,  16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    // Both fractions equal (on the diagonal), then either side of it.
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh00FF, 16'sh00FF, 1'b0, 18'd0, 1'b0},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0000, 16'sh00FF, 1'b0, 18'd0, 1'b0},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh00FF, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0080, 16'sh0081, 1'b0, 18'd0, 1'b0},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh0081, 16'sh0080, 1'b0, 18'd0, 1'b0},
    // Index extremes of the store.
    '{MODE_LOAD,  16'hFFFF,  10'd1023, 16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_LOAD,  16'd0,     10'd0,    16'sh0000, 16'sh0000, 1'b0, 18'd0, 1'b0},
    '{MODE_QUERY, 16'd0,     10'd0,    16'sh8000, 16'sh8000, 1'b1, 18'd0, 1'b1}
  };

  // Settings for the random phases, the first one being the reset setting.
  // They take in the register extremes, even sizes, and sizes too small to
  // hold any cell at all.
  setting_t settings [11] = '{
    '{255, 255, 1638,  40},
    '{3,   3,   65535, 50},
    '{255, 255, 0,     30},
    '{7,   9,   -1,    70},
    '{6,   4,   -1,    40},
    '{1,   5,   -1,    15},
    '{2,   2,   -1,    30},
    '{255, 3,   1,     40},
    '{13,  255, -1,    60},
    '{0,   7,   -1,    10},
    '{11,  11,  -1,    60}
  };

  // Idle gap or stall length: mostly none or short, now and then long.
  function automatic int pick_gap(input bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Locates the cell of a query under the current grid size. The returned
  // flag is set when the cell does not lie wholly inside the grid; the four
  // store indices are those of the upper-left, upper-right, lower-left and
  // lower-right corners (row 0 is the top row).
  function automatic bit cell_outside(input logic signed [15:0] qx, qy,
                                      output int i01, i11, i00, i10);
    int rows, cols, nx, ny, row_top, col_left;
    rows     = cfg_rows;
    cols     = cfg_cols;
    nx       = int'(qx) >>> FRAC_BITS;
    ny       = int'(qy) >>> FRAC_BITS;
    row_top  = (rows - 1) / 2 - ny - 1;
    col_left = (cols - 1) / 2 + nx;
    i01      = row_top * cols + col_left;
    i11      = i01 + 1;
    i00      = i01 + cols;
    i10      = i00 + 1;
    return rows < 2 || cols < 2 || row_top < 0 || row_top > rows - 2 ||
           col_left < 0 || col_left > cols - 2 || i10 >= STORE_DEPTH;
  endfunction

  // Planar interpolation over the triangle picked by the diagonal split,
  // followed by the Q0.16 scale and saturation to the output width.
  function automatic height_word_t predict_height(input logic signed [15:0] qx, qy);
    height_word_t      r;
    int                i01, i11, i00, i10;
    longint            h01, h11, h00, h10, fx, fy, s, scaled;
    r.height       = '0;
    r.out_of_range = 1'b1;
    if (cell_outside(qx, qy, i01, i11, i00, i10)) return r;
    h01 = samples[i01];
    h11 = samples[i11];
    h00 = samples[i00];
    h10 = samples[i10];
    fx  = qx[FRAC_BITS-1:0];
    fy  = qy[FRAC_BITS-1:0];
    if (fx < fy)
      s = h01 * ONE + fx * (h11 - h01) + (ONE - fy) * (h00 - h01);
    else
      s = h10 * ONE + (ONE - fx) * (h00 - h10) + fy * (h11 - h10);
    if (s < 0) s = 0;
    scaled = (s * longint'(cfg_scale)) >>> 16;
    if (scaled > longint'(HEIGHT_MAX)) scaled = longint'(HEIGHT_MAX);
    r.height       = scaled[HGT_W-1:0];
    r.out_of_range = 1'b0;
    return r;
  endfunction

  // A load word with index, value and both coordinates random, so that the
  // fields a mode does not use still toggle.
  function automatic in_word_t blank_word();
    in_word_t w;
    w.mode  = MODE_LOAD;
    w.idx   = 16'($urandom);
    w.val   = SMP_W'($urandom);
    w.qx    = 16'($urandom);
    w.qy    = 16'($urandom);
    w.fixed = 1'b0;
    w.fh    = '0;
    w.foor  = 1'b0;
    return w;
  endfunction

  // Offers one word after a random gap and returns at the falling edge that
  // follows its acceptance. Valid stays high if the next word follows with
  // no gap, so it is never dropped and raised within one time step.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap(tx_quiet || hold_req);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode         = w.mode;
    load_index   = w.idx;
    load_value   = w.val;
    query_x      = w.qx;
    query_y      = w.qy;
    cur_fixed    = w.fixed;
    cur_expected = '{w.fh, w.foor};
    in_valid     = 1'b1;
    if (w.mode == MODE_LOAD) loaded[w.idx] = 1'b1;
    words_sent++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Loads any corner of the query's cell that has never been written, with
  // random content, so that the query itself is always well formed.
  task automatic fill_corners(input logic signed [15:0] qx, qy);
    int       corner [4];
    in_word_t w;
    if (cell_outside(qx, qy, corner[0], corner[1], corner[2], corner[3])) return;
    foreach (corner[k]) begin
      if (!loaded[corner[k]]) begin
        w      = blank_word();
        w.mode = MODE_LOAD;
        w.idx  = corner[k][15:0];
        send_word(w);
      end
    end
  endtask

  // Random traffic under the current setting. Most words are queries into a
  // cell inside the grid, with the fractions often equal so that the diagonal
  // is hit; the rest are reloads inside the grid, loads anywhere in the store
  // and queries at arbitrary positions. With squeeze set, the receiver is
  // asked early on for its long hold-off while this side keeps offering.
  task automatic run_random(input int quota, input bit squeeze);
    in_word_t w;
    int       start, kind, rows, cols, rt, ct, fx, fy;
    start = words_sent;
    rows  = cfg_rows;
    cols  = cfg_cols;
    while (words_sent - start < quota) begin
      if (squeeze && words_sent - start == 10) hold_req = 1'b1;
      kind = $urandom_range(0, 99);
      w    = blank_word();
      if (kind < 70 && rows >= 2 && cols >= 2) begin
        rt     = $urandom_range(0, rows - 2);
        ct     = $urandom_range(0, cols - 2);
        fx     = $urandom_range(0, ONE - 1);
        fy     = ($urandom_range(0, 4) == 0) ? fx : $urandom_range(0, ONE - 1);
        w.mode = MODE_QUERY;
        w.qx   = 16'((ct - (cols - 1) / 2) * ONE + fx);
        w.qy   = 16'(((rows - 1) / 2 - 1 - rt) * ONE + fy);
      end else if (kind >= 70 && kind < 80 && rows * cols > 0) begin
        w.idx  = 16'($urandom_range(0, rows * cols - 1));
      end else if (kind >= 80 && kind < 90) begin
        w.mode = MODE_LOAD;
      end else begin
        w.mode = MODE_QUERY;
      end
      if (w.mode == MODE_QUERY) fill_corners(w.qx, w.qy);
      send_word(w);
    end
  endtask

  // Waits until every expected result has come, then lets any loads still in
  // the pipeline drain out before the registers may be touched.
  task automatic drain();
    in_valid = 1'b0;
    while (heights_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB write: setup cycle, then access cycle, written at the rising
  // edge where the access phase meets pready. psel is left high so that
  // back-to-back writes need no second assignment in the same step.
  task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    case (r)
      REG_GRID_COLS:    cfg_cols  = v[7:0];
      REG_GRID_ROWS:    cfg_rows  = v[7:0];
      REG_HEIGHT_SCALE: cfg_scale = v[15:0];
      default: ;
    endcase
  endtask

  // Receiver: runs of readiness broken by stalls of random length, and once
  // a long hold-off, counted here, which fills the pipeline and must push
  // back on the input side.
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        stall = pick_gap(rx_quiet);
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  // Observes both channels at the rising edge. An accepted load updates our
  // store copy; an accepted query queues its expected result, and each result
  // that leaves the block is compared with the oldest one queued.
  always @(posedge clk) begin : observe
    height_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (mode == MODE_LOAD) begin
          samples[load_index] = load_value;
        end else begin
          want = cur_fixed ? cur_expected : predict_height(query_x, query_y);
          heights_due.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (heights_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: height %0d, out_of_range %0b",
                   $time, height, out_of_range);
        end else begin
          want = heights_due.pop_front();
          if (height !== want.height) begin
            errors++;
            $display("%0t: height expected %0d, got %0d", $time, want.height, height);
          end
          if (out_of_range !== want.out_of_range) begin
            errors++;
            $display("%0t: out_of_range expected %0b, got %0b",
                     $time, want.out_of_range, out_of_range);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int scale;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    mode       = MODE_LOAD;
    load_index = '0;
    load_value = '0;
    query_x    = '0;
    query_y    = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset setting.
    foreach (directed_words[i]) send_word(directed_words[i]);

    // Random phases; every phase but the first rewrites all three registers
    // once the block is idle.
    foreach (settings[p]) begin
      if (p > 0) begin
        drain();
        scale = (settings[p].scale < 0) ? $urandom_range(0, 65535) : settings[p].scale;
        write_reg(REG_GRID_COLS, 32'(settings[p].cols));
        write_reg(REG_GRID_ROWS, 32'(settings[p].rows));
        write_reg(REG_HEIGHT_SCALE, 32'(scale));
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      run_random(settings[p].words, p == 3);
    end

    drain();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
